// ===== src/instruction_length_and_field_decoder_top_defines.svh =====
// ----------------------------------------------------------------------------
// Instruction length and field decoder: assertion macros
// Shared concurrent assertion forms for the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef INSTRUCTION_LENGTH_AND_FIELD_DECODER_TOP_DEFINES_SVH
`define INSTRUCTION_LENGTH_AND_FIELD_DECODER_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define ILD_ASSERT_IMP(lbl, clk_i, rstn_i, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ILD_ASSERT_NXT(lbl, clk_i, rstn_i, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/ild_pkg.sv =====
// ----------------------------------------------------------------------------
// ild_pkg
// Operation codes, field kinds and the decoded item type of the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ild_pkg;

	typedef enum logic [4:0] {
		OP_ADD    = 5'd0,
		OP_SUB    = 5'd1,
		OP_AND    = 5'd2,
		OP_OR     = 5'd3,
		OP_XOR    = 5'd4,
		OP_MOVE   = 5'd5,
		OP_CMP    = 5'd6,
		OP_LOAD   = 5'd7,
		OP_STORE  = 5'd8,
		OP_ASR    = 5'd9,
		OP_LSR    = 5'd10,
		OP_LSL    = 5'd11,
		OP_NOT    = 5'd12,
		OP_NEG    = 5'd13,
		OP_MUL    = 5'd14,
		OP_DIV    = 5'd15,
		OP_HRD    = 5'd16,
		OP_HWR    = 5'd17,
		OP_JUMP   = 5'd18,
		OP_CALL   = 5'd19,
		OP_BRANCH = 5'd20,
		OP_RET    = 5'd21,
		OP_FLAG   = 5'd22,
		OP_NOP    = 5'd23,
		OP_WAIT   = 5'd24,
		OP_UNDEF  = 5'd25
	} ild_op_t;

	// second operand source
	localparam logic [1:0] SRC_NONE = 2'd0;
	localparam logic [1:0] SRC_REG  = 2'd1;
	localparam logic [1:0] SRC_IMM  = 2'd2;

	// memory or jump base
	localparam logic [1:0] BASE_NONE = 2'd0;
	localparam logic [1:0] BASE_REG  = 2'd1;
	localparam logic [1:0] BASE_SP   = 2'd2;
	localparam logic [1:0] BASE_ABS  = 2'd3;

	// control flow kind
	localparam logic [1:0] FLOW_PLAIN = 2'd0;
	localparam logic [1:0] FLOW_CALL  = 2'd1;
	localparam logic [1:0] FLOW_RET   = 2'd2;

	localparam logic [3:0] COND_ALWAYS = 4'd5;

	// low opcode nibble values; LO_JUMP picks the jump form over the call form
	localparam logic [3:0] LO_JUMP = 4'd8;
	localparam logic [3:0] LO_NOP  = 4'd12;
	localparam logic [3:0] LO_WAIT = 4'd14;
	localparam logic [3:0] LO_FLAG_MAX = 4'd9;
	localparam logic [3:0] LO_RET_MAX  = 4'd3;

	// length in bytes from the top three opcode bits
	localparam logic [2:0] LEN_TABLE [8] = '{3'd4, 3'd3, 3'd3, 3'd2, 3'd2, 3'd2, 3'd2, 3'd1};

	typedef struct packed {
		logic [2:0]  length;
		ild_op_t     operation;
		logic [3:0]  variant;
		logic [3:0]  condition;
		logic [2:0]  reg_a;
		logic [2:0]  reg_b;
		logic [2:0]  reg_c;
		logic [1:0]  operand_source;
		logic [1:0]  base_kind;
		logic [31:0] immediate;
		logic [31:0] target;
		logic [1:0]  flow;
	} ild_dec_t;

endpackage

`default_nettype wire

// ===== src/ild_decode.sv =====
// ----------------------------------------------------------------------------
// ild_decode
// Combinational decode of one fetch window into length, class and fields.
// ----------------------------------------------------------------------------
`default_nettype none

module ild_decode (
	input  wire logic [31:0]       fetch_window,
	input  wire logic [31:0]       pc,
	output ild_pkg::ild_dec_t      dec
);
	import ild_pkg::*;

	logic [2:0]  len;
	logic [31:0] w;
	logic [3:0]  row;
	logic [3:0]  lo;
	logic [2:0]  pr;
	logic [2:0]  ra;
	logic [2:0]  rb;
	logic [2:0]  rc;
	logic [31:0] i19s, i19u, i22s, i22h, i14s, i14h, i11s, f11u, i6s, f6u, i3s, f3u;
	logic [31:0] r16, r8, a24;
	logic [31:0] rel_ofs;
	logic [31:0] rel_tgt;
	logic [3:0]  st_var;
	ild_op_t     logic_op;
	ild_op_t     shift_op;

	assign len = LEN_TABLE[fetch_window[31:29]];

	// bytes past the length read as zero
	always_comb begin
		unique case (len)
			3'd1:    w = {fetch_window[31:24], 24'd0};
			3'd2:    w = {fetch_window[31:16], 16'd0};
			3'd3:    w = {fetch_window[31:8], 8'd0};
			default: w = fetch_window;
		endcase
	end

	assign row = w[31:28];
	assign lo  = w[27:24];
	assign pr  = w[27:25];
	assign ra  = w[24:22];
	assign rb  = w[21:19];
	assign rc  = w[18:16];

	assign i19s = {{13{w[18]}}, w[18:0]};
	assign i19u = {13'd0, w[18:0]};
	assign i22s = {{10{w[21]}}, w[21:0]};
	assign i22h = {w[21:0], 10'd0};
	assign i14s = {{18{w[21]}}, w[21:8]};
	assign i14h = {w[21:8], 18'd0};
	assign i11s = {{21{w[18]}}, w[18:8]};
	assign f11u = {21'd0, w[18:8]};
	assign i6s  = {{26{w[21]}}, w[21:16]};
	assign f6u  = {26'd0, w[21:16]};
	assign i3s  = {{29{w[18]}}, w[18:16]};
	assign f3u  = {29'd0, w[18:16]};
	assign r16  = {{16{w[23]}}, w[23:8]};
	assign r8   = {{24{w[23]}}, w[23:16]};
	assign a24  = {8'd0, w[23:0]};

	// one adder serves both pc-relative forms
	assign rel_ofs = (row == 4'h2) ? r16 : r8;
	assign rel_tgt = pc + rel_ofs;

	// store sizes 0, 2, 4 for pr 5, 6, 7
	assign st_var = {1'b0, pr - 3'd5} << 1;

	always_comb begin
		unique case (pr)
			3'd5:    logic_op = OP_AND;
			3'd6:    logic_op = OP_OR;
			default: logic_op = OP_XOR;
		endcase
		unique case (pr)
			3'd5:    shift_op = OP_ASR;
			3'd6:    shift_op = OP_LSR;
			default: shift_op = OP_LSL;
		endcase
	end

	always_comb begin
		dec                = '0;
		dec.length         = len;
		dec.operation      = OP_UNDEF;
		unique case (row)
			4'h0, 4'h2: begin
				if (pr == 3'd4) begin
					dec.operation = (lo == LO_JUMP) ? ((row == 4'h0) ? OP_JUMP : OP_BRANCH)
						: OP_CALL;
					dec.flow      = (lo == LO_JUMP) ? FLOW_PLAIN : FLOW_CALL;
					dec.condition = COND_ALWAYS;
					if (row == 4'h0) begin
						dec.base_kind = BASE_ABS;
						dec.immediate = a24;
						dec.target    = a24;
					end else begin
						dec.base_kind = BASE_NONE;
						dec.immediate = r16;
						dec.target    = rel_tgt;
					end
				end else begin
					dec.reg_a          = ra;
					dec.operand_source = SRC_IMM;
					unique case (pr)
						3'd0: begin
							dec.operation = OP_ADD;
							dec.reg_b     = rb;
							dec.immediate = (row == 4'h0) ? i19s : i11s;
						end
						3'd1: begin
							dec.operation = OP_MOVE;
							dec.immediate = (row == 4'h0) ? i22h : i14h;
						end
						3'd2: begin
							dec.operation = OP_SUB;
							dec.reg_b     = rb;
							dec.immediate = (row == 4'h0) ? i19s : i11s;
						end
						3'd3: begin
							dec.operation = (row == 4'h0) ? OP_MOVE : OP_CMP;
							dec.immediate = (row == 4'h0) ? i22s : i14s;
						end
						default: begin
							dec.operation = logic_op;
							dec.reg_b     = rb;
							dec.immediate = (row == 4'h0) ? i19u : f11u;
						end
					endcase
				end
			end
			4'h1, 4'h3, 4'h4, 4'h5, 4'h7, 4'h9: begin
				if (pr < 3'd5) begin
					dec.operation = OP_LOAD;
					dec.variant   = {1'b0, pr};
				end else begin
					dec.operation = OP_STORE;
					dec.variant   = st_var;
				end
				dec.reg_a          = ra;
				dec.operand_source = SRC_IMM;
				unique case (row)
					4'h1: begin
						dec.base_kind = BASE_REG;
						dec.reg_b     = rb;
						dec.immediate = i19s;
					end
					4'h3: begin
						dec.base_kind = BASE_SP;
						dec.immediate = i14s;
					end
					4'h4: begin
						dec.base_kind = BASE_REG;
						dec.reg_b     = rb;
						dec.immediate = i11s;
					end
					4'h5: begin
						dec.base_kind = BASE_ABS;
						dec.immediate = i14s;
					end
					4'h7: begin
						dec.base_kind = BASE_SP;
						dec.immediate = i6s;
					end
					default: begin
						dec.base_kind = BASE_REG;
						dec.reg_b     = rb;
						dec.immediate = i3s;
					end
				endcase
			end
			4'h6: begin
				if (pr != 3'd4) begin
					dec.reg_a          = ra;
					dec.operand_source = SRC_IMM;
					unique case (pr)
						3'd0: begin
							dec.operation = OP_ADD;
							dec.immediate = i6s;
						end
						3'd1: begin
							dec.operation = OP_MOVE;
							dec.immediate = i6s;
						end
						3'd2: begin
							dec.operation = OP_SUB;
							dec.immediate = i6s;
						end
						3'd3: begin
							dec.operation = OP_CMP;
							dec.immediate = i6s;
						end
						default: begin
							// shift by immediate count, count also shows in reg_c
							dec.operation = shift_op;
							dec.reg_b     = rb;
							dec.reg_c     = rc;
							dec.immediate = f3u;
						end
					endcase
				end
			end
			4'h8: begin
				priority if (pr == 3'd0 || pr == 3'd2 || pr >= 3'd5) begin
					dec.operation      = (pr == 3'd0) ? OP_ADD : (pr == 3'd2) ? OP_SUB : logic_op;
					dec.reg_a          = ra;
					dec.reg_b          = rb;
					dec.reg_c          = rc;
					dec.operand_source = SRC_REG;
				end else if (lo == LO_JUMP) begin
					dec.operation = OP_JUMP;
					dec.base_kind = BASE_REG;
					dec.reg_b     = rb;
					dec.condition = COND_ALWAYS;
				end else begin
					dec.operation = OP_UNDEF;
				end
			end
			4'ha: begin
				priority if (pr < 3'd4) begin
					unique case (pr[1:0])
						2'd0:    dec.operation = OP_NOT;
						2'd1:    dec.operation = OP_MOVE;
						2'd2:    dec.operation = OP_NEG;
						default: dec.operation = OP_CMP;
					endcase
					dec.reg_a = ra;
					dec.reg_b = rb;
				end else if (lo == LO_JUMP) begin
					dec.operation = OP_CALL;
					dec.base_kind = BASE_REG;
					dec.reg_b     = rb;
					dec.condition = COND_ALWAYS;
					dec.flow      = FLOW_CALL;
				end else if (pr >= 3'd5) begin
					dec.operation      = shift_op;
					dec.reg_a          = ra;
					dec.reg_b          = rb;
					dec.reg_c          = rc;
					dec.operand_source = SRC_REG;
				end else begin
					dec.operation = OP_UNDEF;
				end
			end
			4'hb: begin
				if (pr < 3'd4 || pr >= 3'd6) begin
					dec.operation = (pr < 3'd4) ? OP_MUL : OP_DIV;
					dec.variant   = (pr < 3'd4) ? {1'b0, pr} : {3'd0, ~pr[0]};
					dec.reg_a     = ra;
					dec.reg_b     = rb;
				end
			end
			4'hc: begin
				if (pr == 3'd4 || pr == 3'd5) begin
					dec.operation      = (pr == 3'd4) ? OP_HRD : OP_HWR;
					dec.reg_a          = ra;
					dec.operand_source = SRC_IMM;
					dec.immediate      = f6u;
				end
			end
			4'hd: begin
				dec.operation = OP_BRANCH;
				dec.condition = lo;
				dec.immediate = r8;
				dec.target    = rel_tgt;
			end
			4'he: begin
				if (lo <= LO_RET_MAX) begin
					dec.operation = OP_RET;
					dec.variant   = lo;
					dec.condition = COND_ALWAYS;
					dec.flow      = FLOW_RET;
				end
			end
			default: begin
				priority if (lo <= LO_FLAG_MAX) begin
					dec.operation = OP_FLAG;
					dec.variant   = lo;
				end else if (lo == LO_NOP) begin
					dec.operation = OP_NOP;
				end else if (lo == LO_WAIT) begin
					dec.operation = OP_WAIT;
				end else begin
					dec.operation = OP_UNDEF;
				end
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== src/instruction_length_and_field_decoder_top.sv =====
// ----------------------------------------------------------------------------
// instruction_length_and_field_decoder_top
// Decodes one fetch window per cycle, unless out_ready stalls, into length, operation and fields.
//
//   channel  direction  handshake            payload
//   in       into block in_valid / in_ready  fetch_window, pc
//   out      from block out_valid/out_ready  length .. flow (12 fields)
//
// From acceptance to result an item passes the input register, then the result register.
// One item per cycle sustained while out_ready is high; the decode and the pc-relative adder sit
// between the two registers.
// A stalled result holds in the result register while the input register
// still takes one more item.
// arst_n clears both valid flags; payload registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "instruction_length_and_field_decoder_top_defines.svh"

module instruction_length_and_field_decoder_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [31:0] fetch_window,
	input  wire logic [31:0] pc,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       length,
	output logic [4:0]       operation,
	output logic [3:0]       variant,
	output logic [3:0]       condition,
	output logic [2:0]       reg_a,
	output logic [2:0]       reg_b,
	output logic [2:0]       reg_c,
	output logic [1:0]       operand_source,
	output logic [1:0]       base_kind,
	output logic [31:0]      immediate,
	output logic [31:0]      target,
	output logic [1:0]       flow
);
	import ild_pkg::*;

	logic        v_s1;
	logic [31:0] win_s1;
	logic [31:0] pc_s1;
	logic        v_s2;
	ild_dec_t    dec_s2;
	ild_dec_t    dec_d;
	logic        adv_s2;

	// result register can take a new item
	assign adv_s2   = !v_s2 || out_ready;
	assign in_ready = !v_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			win_s1 <= fetch_window;
			pc_s1  <= pc;
		end
		if (adv_s2 && v_s1) begin
			dec_s2 <= dec_d;
		end
	end

	ild_decode u_decode (
		.fetch_window(win_s1),
		.pc          (pc_s1),
		.dec         (dec_d)
	);

	assign out_valid      = v_s2;
	assign length         = dec_s2.length;
	assign operation      = dec_s2.operation;
	assign variant        = dec_s2.variant;
	assign condition      = dec_s2.condition;
	assign reg_a          = dec_s2.reg_a;
	assign reg_b          = dec_s2.reg_b;
	assign reg_c          = dec_s2.reg_c;
	assign operand_source = dec_s2.operand_source;
	assign base_kind      = dec_s2.base_kind;
	assign immediate      = dec_s2.immediate;
	assign target         = dec_s2.target;
	assign flow           = dec_s2.flow;

	`ILD_ASSERT_NXT(a_stage_advance, clk, arst_n, v_s1 && adv_s2, v_s2, "item lost between stages")
	`ILD_ASSERT_IMP(a_undef_clean, clk, arst_n, v_s2 && operation == OP_UNDEF, variant == 4'd0 && target == 32'd0 && flow == FLOW_PLAIN && base_kind == BASE_NONE, "undefined item carries fields")
	`ILD_ASSERT_IMP(a_call_flow, clk, arst_n, v_s2 && flow == FLOW_CALL, operation == OP_CALL && condition == COND_ALWAYS, "call flow on non-call")
	`ILD_ASSERT_IMP(a_ret_flow, clk, arst_n, v_s2 && flow == FLOW_RET, operation == OP_RET && variant <= 4'd3, "return flow on non-return")
	`ILD_ASSERT_IMP(a_len_range, clk, arst_n, v_s2, length != 3'd0 && length <= 3'd4, "length out of range")

endmodule

`default_nettype wire

// ===== tb/instruction_length_and_field_decoder_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// instruction_length_and_field_decoder_top_test
// Feeds fetch windows and pcs through the decoder under random valid and ready
// gaps and compares every decoded result, field by field and in order, with
// a behavioral decode of the same window.
// ----------------------------------------------------------------------------

module instruction_length_and_field_decoder_top_test;

	import ild_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [31:0] fetch_window = '0;
	logic [31:0] pc = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  length;
	logic [4:0]  operation;
	logic [3:0]  variant;
	logic [3:0]  condition;
	logic [2:0]  reg_a;
	logic [2:0]  reg_b;
	logic [2:0]  reg_c;
	logic [1:0]  operand_source;
	logic [1:0]  base_kind;
	logic [31:0] immediate;
	logic [31:0] target;
	logic [1:0]  flow;

	// idle chance per cycle, in percent
	int send_idle = 34;
	int recv_idle = 48;

	instruction_length_and_field_decoder_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.fetch_window(fetch_window),
		.pc(pc),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.length(length),
		.operation(operation),
		.variant(variant),
		.condition(condition),
		.reg_a(reg_a),
		.reg_b(reg_b),
		.reg_c(reg_c),
		.operand_source(operand_source),
		.base_kind(base_kind),
		.immediate(immediate),
		.target(target),
		.flow(flow)
	);

	class decode_scoreboard;
		ild_dec_t pending_decodes[$];
		int       errors = 0;

		function void note_fetch(ild_dec_t want);
			pending_decodes.push_back(want);
		endfunction

		function int waiting();
			return pending_decodes.size();
		endfunction

		function void report(string what, logic [31:0] want, logic [31:0] got);
			errors++;
			if (errors <= 10) begin
				$display("%0t: mismatch on %s: expected %h, got %h", $time, what, want, got);
			end
		endfunction

		function void compare_field(string what, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				report(what, want, got);
			end
		endfunction

		function void check_decode(ild_dec_t got);
			ild_dec_t want;
			if (pending_decodes.size() == 0) begin
				report("result with no item pending", '0, got.immediate);
				return;
			end
			want = pending_decodes.pop_front();
			compare_field("length", 32'(want.length), 32'(got.length));
			compare_field("operation", 32'(want.operation), 32'(got.operation));
			compare_field("variant", 32'(want.variant), 32'(got.variant));
			compare_field("condition", 32'(want.condition), 32'(got.condition));
			compare_field("reg_a", 32'(want.reg_a), 32'(got.reg_a));
			compare_field("reg_b", 32'(want.reg_b), 32'(got.reg_b));
			compare_field("reg_c", 32'(want.reg_c), 32'(got.reg_c));
			compare_field("operand_source", 32'(want.operand_source),
				32'(got.operand_source));
			compare_field("base_kind", 32'(want.base_kind), 32'(got.base_kind));
			compare_field("immediate", want.immediate, got.immediate);
			compare_field("target", want.target, got.target);
			compare_field("flow", 32'(want.flow), 32'(got.flow));
		endfunction
	endclass

	decode_scoreboard ledger = new();

	function automatic ild_dec_t alu_form(ild_dec_t d, logic [31:0] w, ild_op_t op,
			int use_b, int use_c, logic [1:0] src, logic [31:0] imm);
		d.operation = op;
		d.reg_a = w[24:22];
		if (use_b != 0) begin
			d.reg_b = w[21:19];
		end
		if (use_c != 0) begin
			d.reg_c = w[18:16];
		end
		d.operand_source = src;
		d.immediate = imm;
		return d;
	endfunction

	// pair index below 5 is a load, the top three are byte, word and long stores
	function automatic ild_dec_t mem_form(ild_dec_t d, logic [31:0] w, logic [1:0] base,
			logic [31:0] offset);
		logic [2:0] pair;
		pair = w[27:25];
		if (pair < 3'd5) begin
			d.operation = OP_LOAD;
			d.variant = {1'b0, pair};
		end else begin
			d.operation = OP_STORE;
			d.variant = {pair - 3'd5, 1'b0};
		end
		d.reg_a = w[24:22];
		if (base == BASE_REG) begin
			d.reg_b = w[21:19];
		end
		d.operand_source = SRC_IMM;
		d.base_kind = base;
		d.immediate = offset;
		return d;
	endfunction

	function automatic ild_dec_t flow_form(ild_dec_t d, ild_op_t op, logic [1:0] base,
			logic [31:0] imm, logic [31:0] dest, logic [1:0] kind);
		d.operation = op;
		d.base_kind = base;
		d.immediate = imm;
		d.target = dest;
		d.flow = kind;
		d.condition = COND_ALWAYS;
		return d;
	endfunction

	function automatic ild_dec_t decode_window(logic [31:0] win, logic [31:0] at_pc);
		ild_dec_t    d;
		logic [2:0]  len;
		logic [31:0] w;
		logic [3:0]  lo;
		logic [2:0]  pair;
		ild_op_t     logic_op;
		ild_op_t     shift_op;
		logic [31:0] i19s, i19u, i22s, i22h, i14s, i14h, i11s, i11u, i6s, i6u, i3s, i3u;
		logic [31:0] rel16, rel8, abs24;

		case (win[31:29])
			3'd0: len = 3'd4;
			3'd1, 3'd2: len = 3'd3;
			3'd7: len = 3'd1;
			default: len = 3'd2;
		endcase
		// bytes past the length never reach the decode
		w = win & (32'hffff_ffff << (8 * (4 - int'(len))));
		lo = w[27:24];
		pair = w[27:25];
		logic_op = (pair == 3'd5) ? OP_AND : (pair == 3'd6) ? OP_OR : OP_XOR;
		shift_op = (pair == 3'd5) ? OP_ASR : (pair == 3'd6) ? OP_LSR : OP_LSL;

		i19s = {{13{w[18]}}, w[18:0]};
		i19u = {13'b0, w[18:0]};
		i22s = {{10{w[21]}}, w[21:0]};
		i22h = w << 10;
		i14s = {{18{w[21]}}, w[21:8]};
		i14h = {w[21:8], 18'b0};
		i11s = {{21{w[18]}}, w[18:8]};
		i11u = {21'b0, w[18:8]};
		i6s = {{26{w[21]}}, w[21:16]};
		i6u = {26'b0, w[21:16]};
		i3s = {{29{w[18]}}, w[18:16]};
		i3u = {29'b0, w[18:16]};
		rel16 = {{16{w[23]}}, w[23:8]};
		rel8 = {{24{w[23]}}, w[23:16]};
		abs24 = {8'b0, w[23:0]};

		d = '0;
		d.operation = OP_UNDEF;
		case (w[31:28])
			4'h0: begin
				case (pair)
					3'd0: d = alu_form(d, w, OP_ADD, 1, 0, SRC_IMM, i19s);
					3'd1: d = alu_form(d, w, OP_MOVE, 0, 0, SRC_IMM, i22h);
					3'd2: d = alu_form(d, w, OP_SUB, 1, 0, SRC_IMM, i19s);
					3'd3: d = alu_form(d, w, OP_MOVE, 0, 0, SRC_IMM, i22s);
					3'd4: begin
						if (lo == LO_JUMP) begin
							d = flow_form(d, OP_JUMP, BASE_ABS, abs24, abs24, FLOW_PLAIN);
						end else begin
							d = flow_form(d, OP_CALL, BASE_ABS, abs24, abs24, FLOW_CALL);
						end
					end
					default: d = alu_form(d, w, logic_op, 1, 0, SRC_IMM, i19u);
				endcase
			end
			4'h1: d = mem_form(d, w, BASE_REG, i19s);
			4'h2: begin
				case (pair)
					3'd0: d = alu_form(d, w, OP_ADD, 1, 0, SRC_IMM, i11s);
					3'd1: d = alu_form(d, w, OP_MOVE, 0, 0, SRC_IMM, i14h);
					3'd2: d = alu_form(d, w, OP_SUB, 1, 0, SRC_IMM, i11s);
					3'd3: d = alu_form(d, w, OP_CMP, 0, 0, SRC_IMM, i14s);
					3'd4: begin
						if (lo == LO_JUMP) begin
							d = flow_form(d, OP_BRANCH, BASE_NONE, rel16, at_pc + rel16,
								FLOW_PLAIN);
						end else begin
							d = flow_form(d, OP_CALL, BASE_NONE, rel16, at_pc + rel16,
								FLOW_CALL);
						end
					end
					default: d = alu_form(d, w, logic_op, 1, 0, SRC_IMM, i11u);
				endcase
			end
			4'h3: d = mem_form(d, w, BASE_SP, i14s);
			4'h4: d = mem_form(d, w, BASE_REG, i11s);
			4'h5: d = mem_form(d, w, BASE_ABS, i14s);
			4'h6: begin
				// accumulate forms: reg_a is source and destination; the shift forms also carry reg_b and reg_c
				case (pair)
					3'd0: d = alu_form(d, w, OP_ADD, 0, 0, SRC_IMM, i6s);
					3'd1: d = alu_form(d, w, OP_MOVE, 0, 0, SRC_IMM, i6s);
					3'd2: d = alu_form(d, w, OP_SUB, 0, 0, SRC_IMM, i6s);
					3'd3: d = alu_form(d, w, OP_CMP, 0, 0, SRC_IMM, i6s);
					3'd4: ;
					default: d = alu_form(d, w, shift_op, 1, 1, SRC_IMM, i3u);
				endcase
			end
			4'h7: d = mem_form(d, w, BASE_SP, i6s);
			4'h8: begin
				if (pair == 3'd0) begin
					d = alu_form(d, w, OP_ADD, 1, 1, SRC_REG, '0);
				end else if (pair == 3'd2) begin
					d = alu_form(d, w, OP_SUB, 1, 1, SRC_REG, '0);
				end else if (lo == LO_JUMP) begin
					d = flow_form(d, OP_JUMP, BASE_REG, '0, '0, FLOW_PLAIN);
					d.reg_b = w[21:19];
				end else if (pair >= 3'd5) begin
					d = alu_form(d, w, logic_op, 1, 1, SRC_REG, '0);
				end
			end
			4'h9: d = mem_form(d, w, BASE_REG, i3s);
			4'ha: begin
				if (pair == 3'd0) begin
					d = alu_form(d, w, OP_NOT, 1, 0, SRC_NONE, '0);
				end else if (pair == 3'd1) begin
					d = alu_form(d, w, OP_MOVE, 1, 0, SRC_NONE, '0);
				end else if (pair == 3'd2) begin
					d = alu_form(d, w, OP_NEG, 1, 0, SRC_NONE, '0);
				end else if (pair == 3'd3) begin
					d = alu_form(d, w, OP_CMP, 1, 0, SRC_NONE, '0);
				end else if (lo == LO_JUMP) begin
					d = flow_form(d, OP_CALL, BASE_REG, '0, '0, FLOW_CALL);
					d.reg_b = w[21:19];
				end else if (pair >= 3'd5) begin
					d = alu_form(d, w, shift_op, 1, 1, SRC_REG, '0);
				end
			end
			4'hb: begin
				if (pair < 3'd4) begin
					d = alu_form(d, w, OP_MUL, 1, 0, SRC_NONE, '0);
					d.variant = {1'b0, pair};
				end else if (pair == 3'd6) begin
					d = alu_form(d, w, OP_DIV, 1, 0, SRC_NONE, '0);
					d.variant = 4'd1;
				end else if (pair == 3'd7) begin
					d = alu_form(d, w, OP_DIV, 1, 0, SRC_NONE, '0);
				end
			end
			4'hc: begin
				if (pair == 3'd4) begin
					d = alu_form(d, w, OP_HRD, 0, 0, SRC_IMM, i6u);
				end else if (pair == 3'd5) begin
					d = alu_form(d, w, OP_HWR, 0, 0, SRC_IMM, i6u);
				end
			end
			4'hd: begin
				d.operation = OP_BRANCH;
				d.condition = lo;
				d.immediate = rel8;
				d.target = at_pc + rel8;
			end
			4'he: begin
				if (lo <= LO_RET_MAX) begin
					d = flow_form(d, OP_RET, BASE_NONE, '0, '0, FLOW_RET);
					d.variant = lo;
				end
			end
			default: begin
				if (lo <= LO_FLAG_MAX) begin
					d.operation = OP_FLAG;
					d.variant = lo;
				end else if (lo == LO_NOP) begin
					d.operation = OP_NOP;
				end else if (lo == LO_WAIT) begin
					d.operation = OP_WAIT;
				end
			end
		endcase
		d.length = len;
		return d;
	endfunction

	always #2 clk = ~clk;

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_idle);
	end

	always @(posedge clk) begin : watch_results
		ild_dec_t got;
		if (arst_n && out_valid === 1'b1 && out_ready === 1'b1) begin
			got.length = length;
			got.operation = ild_op_t'(operation);
			got.variant = variant;
			got.condition = condition;
			got.reg_a = reg_a;
			got.reg_b = reg_b;
			got.reg_c = reg_c;
			got.operand_source = operand_source;
			got.base_kind = base_kind;
			got.immediate = immediate;
			got.target = target;
			got.flow = flow;
			ledger.check_decode(got);
		end
	end

	task automatic feed_item(input logic [31:0] win, input logic [31:0] at_pc);
		while ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		fetch_window <= win;
		pc <= at_pc;
		@(posedge clk);
		while (in_ready !== 1'b1) begin
			@(posedge clk);
		end
		ledger.note_fetch(decode_window(win, at_pc));
	endtask

	// hold the sender off until every decode has come back
	task automatic drain_decodes();
		in_valid <= 1'b0;
		while (ledger.waiting() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic run_random(input int count);
		logic [7:0]  opcode;
		logic [23:0] tail;
		logic [31:0] at_pc;
		for (int n = 0; n < count; n++) begin
			opcode = 8'($urandom_range(0, 255));
			case ($urandom_range(0, 3))
				0: tail = '0;
				1: tail = '1;
				default: tail = 24'($urandom);
			endcase
			// pcs near both ends make the relative targets wrap
			case ($urandom_range(0, 3))
				0: at_pc = $urandom_range(0, 255);
				1: at_pc = 32'hffff_ffff - $urandom_range(0, 255);
				default: at_pc = $urandom;
			endcase
			feed_item({opcode, tail}, at_pc);
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		feed_item(32'h0000_0000, 32'h0000_0000);
		feed_item(32'h03ff_ffff, 32'hffff_ffff);
		feed_item(32'h0720_0000, 32'h0000_0000);
		feed_item(32'h05c7_ffff, 32'h8000_0000);
		feed_item(32'h08fe_dcba, 32'h1234_5678);
		feed_item(32'h0912_3456, 32'hffff_ffff);
		feed_item(32'h0a7f_ffff, 32'h0000_0000);
		feed_item(32'h0e78_0000, 32'h0000_0000);
		feed_item(32'h1eff_ffff, 32'h0000_0000);
		feed_item(32'h1004_0000, 32'h0000_0000);
		feed_item(32'h2880_00ab, 32'h0000_0004);
		feed_item(32'h297f_ff00, 32'hffff_fff0);
		feed_item(32'h26ff_ff5a, 32'h0000_0000);
		feed_item(32'h33ff_ffff, 32'h0000_0000);
		feed_item(32'h5cff_ffff, 32'h0000_0000);
		feed_item(32'h6720_ffff, 32'h0000_0000);
		feed_item(32'h6cff_1234, 32'h0000_0000);
		feed_item(32'h68ff_ffff, 32'h0000_0000);
		feed_item(32'h8cff_ffff, 32'h0000_0000);
		feed_item(32'h88ff_ffff, 32'h0000_0000);
		feed_item(32'ha8ff_ffff, 32'h0000_0000);
		feed_item(32'ha0ff_ffff, 32'h0000_0000);
		feed_item(32'ha4c8_0000, 32'h0000_0000);
		feed_item(32'haaff_ffff, 32'h0000_0000);
		feed_item(32'hb6ff_0000, 32'h0000_0000);
		feed_item(32'hbcff_ffff, 32'h0000_0000);
		feed_item(32'hc8ff_ffff, 32'h0000_0000);
		feed_item(32'hcaff_ffff, 32'h0000_0000);
		feed_item(32'hd07f_0000, 32'hffff_fff0);
		feed_item(32'hd5ff_0000, 32'h0000_0000);
		feed_item(32'he3ff_ffff, 32'h0000_0000);
		feed_item(32'hf9ff_ffff, 32'h0000_0000);
		feed_item(32'hfcff_ffff, 32'h0000_0000);
		feed_item(32'hfe00_0000, 32'h0000_0000);
		feed_item(32'hffff_ffff, 32'hffff_ffff);
		drain_decodes();

		run_random(410);
		drain_decodes();

		send_idle = 48;
		recv_idle = 34;
		run_random(410);
		drain_decodes();

		send_idle = 0;
		recv_idle = 0;
		run_random(410);
		drain_decodes();

		// two register stages, so a stray late result shows up during the wait below
		repeat (8) @(posedge clk);
		if (ledger.errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
